@@ sv/sra_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot receipt allocator package
// Sizes, action and status codes and the controller state type shared by the
// interfaces and the top level.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int SLOTS      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);

  // Field widths of the request and response beats.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SCAN = 5'b00100,
    S_TAIL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

@@ sv/sra_if.sv @@
// ----------------------------------------------------------------------------
// Slot receipt allocator channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface sra_req_if;
  logic                             valid;
  logic                             ready;
  logic [sra_pkg::ACTION_W-1:0]     action;
  logic [sra_pkg::ITEM_WIDTH-1:0]   item_value;
  logic [sra_pkg::INDEX_W-1:0]      slot_index;

  modport source (output valid, output action, output item_value, output slot_index,
                  input ready);
  modport sink   (input valid, input action, input item_value, input slot_index,
                  output ready);
endinterface

interface sra_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [sra_pkg::INDEX_W-1:0]      receipt;
  logic [sra_pkg::ITEM_WIDTH-1:0]   item_out;
  logic [sra_pkg::CNT_W-1:0]        match_count;
  logic                             found;
  logic [sra_pkg::CNT_W-1:0]        occupancy;
  logic [sra_pkg::STATUS_W-1:0]     status;

  modport source (output valid, output receipt, output item_out, output match_count,
                  output found, output occupancy, output status, input ready);
  modport sink   (input valid, input receipt, input item_out, input match_count,
                  input found, input occupancy, input status, output ready);
endinterface

@@ sv/sra_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/slot_receipt_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Slot receipt allocator
// Table of slots with valid bits; add, remove by receipt, clear and count.
// ----------------------------------------------------------------------------
// Items live in a single-port-read RAM of SLOTS entries; the valid bits and the
// occupancy are flip-flops that reset clears at once, so the block is ready in
// the first cycle after reset. One request is handled at a time. Add and clear
// go from acceptance through the done state to the response beat, remove also
// passes through a read state because of the registered RAM read, and count
// passes through a scan and a tail state because it reads every slot of the
// RAM in turn, one per cycle, and compares it with the requested item. The
// response sits in an output register, so a new request can be accepted while
// the last response still waits to be taken. Removing a slot that was never
// written returns whatever the RAM holds there.
module slot_receipt_allocator_top (
  input  logic           clk,
  input  logic           rst,
  sra_req_if.sink        req,
  sra_rsp_if.source      rsp
);

  sra_pkg::state_t state;

  logic [sra_pkg::SLOTS-1:0]      slot_valid;
  logic [sra_pkg::CNT_W-1:0]      valid_count;

  logic [sra_pkg::SLOT_W-1:0]     scan_idx;
  logic [sra_pkg::SLOT_W-1:0]     cmp_idx;
  logic                           cmp_valid;
  logic [sra_pkg::ITEM_WIDTH-1:0] value_q;
  logic [sra_pkg::CNT_W-1:0]      match_cnt;

  logic [sra_pkg::INDEX_W-1:0]    pend_receipt;
  logic [sra_pkg::ITEM_WIDTH-1:0] pend_item;
  logic [sra_pkg::STATUS_W-1:0]   pend_status;
  logic                           pend_in_range;
  logic                           pend_count;

  logic                           rsp_valid;
  logic [sra_pkg::INDEX_W-1:0]    out_receipt;
  logic [sra_pkg::ITEM_WIDTH-1:0] out_item;
  logic [sra_pkg::CNT_W-1:0]      out_match;
  logic                           out_found;
  logic [sra_pkg::CNT_W-1:0]      out_occupancy;
  logic [sra_pkg::STATUS_W-1:0]   out_status;

  logic                           accept;
  logic                           free_found;
  logic [sra_pkg::SLOT_W-1:0]     free_idx;
  logic                           idx_in_range;
  logic [sra_pkg::SLOT_W-1:0]     req_slot;
  logic                           ram_we;
  logic [sra_pkg::SLOT_W-1:0]     ram_raddr;
  logic [sra_pkg::ITEM_WIDTH-1:0] ram_rdata;
  logic                           hit;
  logic                           rsp_free;

  assign req.ready = (state == sra_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign req_slot  = req.slot_index[sra_pkg::SLOT_W-1:0];
  assign idx_in_range = (int'(req.slot_index) < sra_pkg::SLOTS);

  // Lowest free slot: scanning downwards leaves the lowest one standing.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = sra_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = sra_pkg::SLOT_W'(i);
      end
    end
  end

  assign ram_we    = accept && (req.action == sra_pkg::ACT_ADD) && free_found;
  assign ram_raddr = (state == sra_pkg::S_SCAN) ? scan_idx : req_slot;

  sra_ram #(
    .WIDTH (sra_pkg::ITEM_WIDTH),
    .DEPTH (sra_pkg::SLOTS)
  ) u_items (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (req.item_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Valid bits do not change during a scan, so the delayed index is safe.
  assign hit      = cmp_valid && slot_valid[cmp_idx] && (ram_rdata == value_q);
  assign rsp_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sra_pkg::S_IDLE;
      slot_valid  <= '0;
      valid_count <= '0;
      rsp_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        sra_pkg::S_IDLE: begin
          if (accept) begin
            pend_receipt  <= '0;
            pend_item     <= '0;
            pend_status   <= sra_pkg::ST_OK;
            pend_count    <= 1'b0;
            match_cnt     <= '0;
            pend_in_range <= idx_in_range;
            value_q       <= req.item_value;
            state         <= sra_pkg::S_DONE;
            case (req.action)
              sra_pkg::ACT_ADD: begin
                if (free_found) begin
                  slot_valid[free_idx] <= 1'b1;
                  valid_count          <= valid_count + 1'b1;
                  pend_receipt         <= sra_pkg::INDEX_W'(free_idx);
                end else begin
                  pend_status <= sra_pkg::ST_FULL;
                end
              end
              sra_pkg::ACT_REMOVE: begin
                pend_receipt <= req.slot_index;
                if (idx_in_range && slot_valid[req_slot]) begin
                  slot_valid[req_slot] <= 1'b0;
                  valid_count          <= valid_count - 1'b1;
                end else begin
                  pend_status <= sra_pkg::ST_FREE;
                end
                state <= sra_pkg::S_RD;
              end
              sra_pkg::ACT_CLEAR: begin
                slot_valid  <= '0;
                valid_count <= '0;
              end
              sra_pkg::ACT_COUNT: begin
                pend_count <= 1'b1;
                scan_idx   <= '0;
                cmp_valid  <= 1'b0;
                state      <= sra_pkg::S_SCAN;
              end
              default: begin
                state <= sra_pkg::S_DONE;
              end
            endcase
          end
        end
        sra_pkg::S_RD: begin
          pend_item <= pend_in_range ? ram_rdata : '0;
          state     <= sra_pkg::S_DONE;
        end
        sra_pkg::S_SCAN: begin
          if (hit) begin
            match_cnt <= match_cnt + 1'b1;
          end
          cmp_valid <= 1'b1;
          cmp_idx   <= scan_idx;
          scan_idx  <= scan_idx + 1'b1;
          if (int'(scan_idx) == sra_pkg::SLOTS - 1) begin
            state <= sra_pkg::S_TAIL;
          end
        end
        sra_pkg::S_TAIL: begin
          if (hit) begin
            match_cnt <= match_cnt + 1'b1;
          end
          cmp_valid <= 1'b0;
          state     <= sra_pkg::S_DONE;
        end
        sra_pkg::S_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= sra_pkg::S_IDLE;
          end
        end
        default: begin
          state <= sra_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Response payload, loaded as the beat is handed over.
  always_ff @(posedge clk) begin
    if ((state == sra_pkg::S_DONE) && rsp_free) begin
      out_receipt   <= pend_receipt;
      out_item      <= pend_item;
      out_match     <= pend_count ? match_cnt : '0;
      out_found     <= pend_count && (match_cnt != '0);
      out_occupancy <= valid_count;
      out_status    <= pend_status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.receipt     = out_receipt;
  assign rsp.item_out    = out_item;
  assign rsp.match_count = out_match;
  assign rsp.found       = out_found;
  assign rsp.occupancy   = out_occupancy;
  assign rsp.status      = out_status;

  a_occupancy_matches_bits: assert property (@(posedge clk) disable iff (rst)
    int'(valid_count) == $countones(slot_valid))
    else $error("occupancy differs from the number of valid slots");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == sra_pkg::S_DONE))
    else $error("response raised outside the completion state");

  a_tail_last_slot: assert property (@(posedge clk) disable iff (rst)
    (state == sra_pkg::S_TAIL) |->
      (cmp_valid && (int'(cmp_idx) == sra_pkg::SLOTS - 1)))
    else $error("scan ended before the last slot was compared");

  a_full_means_all_valid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (out_status == sra_pkg::ST_FULL)) |->
      (int'(out_occupancy) == sra_pkg::SLOTS))
    else $error("full reported while a slot was free");

  a_write_only_to_free: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !slot_valid[free_idx])
    else $error("add wrote into an occupied slot");

endmodule
